### hw/rtl/lcc_pkg.sv
package lcc_pkg;

   localparam int TRACK_SLOTS = 256;
   localparam int SLOT_W = $clog2(TRACK_SLOTS);
   localparam int MAX_LINES = 4;
   localparam int LINE_IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int COORD_W = 14;
   localparam int LINE_W = 58;
   localparam int TOTAL_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int PROD_W = 2 * (COORD_W + 1);
   localparam int CROSS_W = PROD_W + 1;

   localparam logic [1:0] REQ_OBJECT = 2'd0;
   localparam logic [1:0] REQ_SWEEP  = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   localparam logic [1:0] DIR_DOWN  = 2'd0;
   localparam logic [1:0] DIR_UP    = 2'd1;
   localparam logic [1:0] DIR_RIGHT = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   localparam logic [1:0] OUT_NONE = 2'd0;
   localparam logic [1:0] OUT_IN   = 2'd1;
   localparam logic [1:0] OUT_OUT  = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_LINE_COUNT = 3'd0;

   typedef struct packed {
      logic [1:0] req_type;
      logic [8:0] tracker_id;
      logic [11:0] box_x;
      logic [11:0] box_y;
      logic [11:0] box_width;
      logic [11:0] box_height;
   } req_item_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total_out;
      logic [TOTAL_W-1:0] total_in;
      logic [MAX_LINES-1:0] out_lines;
      logic [MAX_LINES-1:0] in_lines;
      logic [1:0] direction;
      logic crossed;
   } rsp_item_type;

   typedef struct packed {
      logic load;
      logic clear_live;
      logic sweep;
      logic read_slot;
      logic prod_a;
      logic prod_b;
      logic judge;
      logic commit;
      logic [LINE_IDX_W-1:0] line_idx;
   } cmd_type;

   typedef struct packed {
      logic is_object;
      logic is_live;
      logic [2:0] line_cnt;
   } status_type;

endpackage

### hw/rtl/line_crossing_counter_core.sv
// Line crossing counter core.
// Sweep/clear: the result register is set as the request is taken. Object: READ,
// then PA, PB and JUDGE per enabled line if the track is live, then DONE.
// Throughput: one item at a time; next item the cycle after the result is taken.
// Synchronous active-high reset clears config, track flags and totals.
module line_crossing_counter_core (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [63:0] req_tdata, // tracker_id, box_x, box_y, box_width, box_height
   input logic [1:0] req_tuser, // req_type
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [79:0] rsp_tdata, // crossed, direction, in_lines, out_lines,
                                  // total_in, total_out
   input logic csr_wr_en,
   input logic [lcc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input logic [lcc_pkg::LINE_W-1:0] csr_wdata
);
   import lcc_pkg::*;

   req_item_type req_item;
   rsp_item_type rsp_item;
   cmd_type cmd;
   status_type status;

   assign req_item.req_type = req_tuser;
   assign req_item.tracker_id = req_tdata[8:0];
   assign req_item.box_x = req_tdata[20:9];
   assign req_item.box_y = req_tdata[32:21];
   assign req_item.box_width = req_tdata[44:33];
   assign req_item.box_height = req_tdata[56:45];

   assign rsp_tdata = {5'b0, rsp_item};

   lcc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_type(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .status(status), .cmd(cmd)
   );

   lcc_datapath u_dp (
      .clock(clock), .reset(reset), .req_item(req_item),
      .csr_wr_en(csr_wr_en), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .cmd(cmd), .status(status), .rsp_item(rsp_item)
   );
endmodule

### hw/rtl/lcc_datapath.sv
module lcc_datapath (
   input logic clock,
   input logic reset,
   input lcc_pkg::req_item_type req_item,
   input logic csr_wr_en,
   input logic [lcc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input logic [lcc_pkg::LINE_W-1:0] csr_wdata,
   input lcc_pkg::cmd_type cmd,
   output lcc_pkg::status_type status,
   output lcc_pkg::rsp_item_type rsp_item
);
   import lcc_pkg::*;

   typedef logic signed [COORD_W:0] scoord_type;
   typedef logic signed [PROD_W-1:0] sprod_type;
   typedef logic signed [CROSS_W-1:0] scross_type;

   logic [2:0] line_cnt_ff;
   logic [LINE_W-1:0] line_ff [MAX_LINES];
   logic [TRACK_SLOTS-1:0] live_ff;
   logic [TRACK_SLOTS-1:0] seen_ff;
   logic [COORD_W-1:0] px_mem [TRACK_SLOTS];
   logic [COORD_W-1:0] py_mem [TRACK_SLOTS];
   logic [MAX_LINES-1:0] cnt_mem [TRACK_SLOTS];

   logic [SLOT_W-1:0] slot_ff;
   logic obj_ff;
   logic [COORD_W-1:0] fx_ff, fy_ff, px_ff, py_ff;
   logic [MAX_LINES-1:0] counted_ff;
   sprod_type pa_ff [4];
   sprod_type pb_ff [4];
   scross_type c_ff [4];
   logic [MAX_LINES-1:0] in_mask_ff, out_mask_ff;
   logic [1:0] dir_ff;
   logic [TOTAL_W-1:0] in_tot_ff, out_tot_ff;

   logic [LINE_W-1:0] cur_line;
   scoord_type x0, y0, x1, y1, spx, spy, sfx, sfy;
   scoord_type d_a [4], d_b [4], d_c [4], d_d [4];
   logic hit, is_in;
   logic [1:0] code;
   logic [2:0] wcnt;

   assign cur_line = line_ff[cmd.line_idx];
   assign x0 = scoord_type'({1'b0, cur_line[13:0]});
   assign y0 = scoord_type'({1'b0, cur_line[27:14]});
   assign x1 = scoord_type'({1'b0, cur_line[41:28]});
   assign y1 = scoord_type'({1'b0, cur_line[55:42]});
   assign code = cur_line[57:56];
   assign spx = scoord_type'({1'b0, px_ff});
   assign spy = scoord_type'({1'b0, py_ff});
   assign sfx = scoord_type'({1'b0, fx_ff});
   assign sfy = scoord_type'({1'b0, fy_ff});

   // c1=(q-p)x(u-p), c2=(q-p)x(v-p), c3=(v-u)x(p-u), c4=(v-u)x(q-u)
   always_comb begin
      d_a[0] = sfx - spx; d_b[0] = y0 - spy;  d_c[0] = sfy - spy; d_d[0] = x0 - spx;
      d_a[1] = sfx - spx; d_b[1] = y1 - spy;  d_c[1] = sfy - spy; d_d[1] = x1 - spx;
      d_a[2] = x1 - x0;   d_b[2] = spy - y0;  d_c[2] = y1 - y0;   d_d[2] = spx - x0;
      d_a[3] = x1 - x0;   d_b[3] = sfy - y0;  d_c[3] = y1 - y0;   d_d[3] = sfx - x0;
   end

   function automatic logic opp(input scross_type a, input scross_type b);
      opp = (a > 0 && b < 0) || (a < 0 && b > 0);
   endfunction

   assign hit = opp(c_ff[0], c_ff[1]) && opp(c_ff[2], c_ff[3])
                && !counted_ff[cmd.line_idx];
   always_comb begin
      unique case (code)
         DIR_UP:    is_in = fy_ff < py_ff;
         DIR_RIGHT: is_in = fx_ff > px_ff;
         DIR_LEFT:  is_in = fx_ff < px_ff;
         default:   is_in = fy_ff > py_ff;
      endcase
   end

   assign wcnt = (csr_wdata[2:0] > 3'(MAX_LINES)) ? 3'(MAX_LINES) : csr_wdata[2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         line_cnt_ff <= '0;
         for (int i = 0; i < MAX_LINES; i++) line_ff[i] <= '0;
         live_ff <= '0;
         seen_ff <= '0;
         in_tot_ff <= '0;
         out_tot_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            if (csr_addr == CSR_LINE_COUNT) line_cnt_ff <= wcnt;
            else if (csr_addr <= CSR_ADDR_W'(MAX_LINES))
               line_ff[LINE_IDX_W'(csr_addr - 3'd1)] <= csr_wdata;
         end
         if (cmd.clear_live) begin
            live_ff <= '0;
            seen_ff <= '0;
         end
         if (cmd.sweep) begin
            live_ff <= live_ff & seen_ff;
            seen_ff <= '0;
         end
         if (cmd.judge && hit) begin
            if (is_in) begin
               if (in_tot_ff != '1) in_tot_ff <= in_tot_ff + 1'b1;
            end else if (out_tot_ff != '1) out_tot_ff <= out_tot_ff + 1'b1;
         end
         if (cmd.commit && obj_ff) begin
            live_ff[slot_ff] <= 1'b1;
            seen_ff[slot_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         slot_ff <= req_item.tracker_id[SLOT_W-1:0];
         obj_ff <= (req_item.req_type == REQ_OBJECT) && !req_item.tracker_id[8];
         fx_ff <= COORD_W'({req_item.box_x, 1'b0}) + COORD_W'(req_item.box_width);
         fy_ff <= COORD_W'({req_item.box_y, 1'b0}) + COORD_W'({req_item.box_height, 1'b0});
         in_mask_ff <= '0;
         out_mask_ff <= '0;
         dir_ff <= OUT_NONE;
      end
      if (cmd.read_slot) begin
         px_ff <= px_mem[slot_ff];
         py_ff <= py_mem[slot_ff];
         counted_ff <= live_ff[slot_ff] ? cnt_mem[slot_ff] : '0;
      end
      if (cmd.prod_a) begin
         for (int i = 0; i < 4; i++) begin
            pa_ff[i] <= d_a[i] * d_b[i];
            pb_ff[i] <= d_c[i] * d_d[i];
         end
      end
      if (cmd.prod_b) begin
         for (int i = 0; i < 4; i++)
            c_ff[i] <= scross_type'(pa_ff[i]) - scross_type'(pb_ff[i]);
      end
      if (cmd.judge && hit) begin
         counted_ff[cmd.line_idx] <= 1'b1;
         if (is_in) begin
            in_mask_ff[cmd.line_idx] <= 1'b1;
            dir_ff <= OUT_IN;
         end else begin
            out_mask_ff[cmd.line_idx] <= 1'b1;
            dir_ff <= OUT_OUT;
         end
      end
      if (cmd.commit && obj_ff) begin
         px_mem[slot_ff] <= fx_ff;
         py_mem[slot_ff] <= fy_ff;
         cnt_mem[slot_ff] <= counted_ff;
      end
   end

   assign status.is_object = obj_ff;
   assign status.is_live = live_ff[slot_ff];
   assign status.line_cnt = line_cnt_ff;

   assign rsp_item.crossed = (in_mask_ff | out_mask_ff) != '0;
   assign rsp_item.direction = dir_ff;
   assign rsp_item.in_lines = in_mask_ff;
   assign rsp_item.out_lines = out_mask_ff;
   assign rsp_item.total_in = in_tot_ff;
   assign rsp_item.total_out = out_tot_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.judge |-> (in_mask_ff & out_mask_ff) == '0)
      else $error("line counted both ways");
   assert property (@(posedge clock) disable iff (reset)
      $past(cmd.commit) && $past(obj_ff) |-> live_ff[$past(slot_ff)])
      else $error("committed track not live");
   assert property (@(posedge clock) disable iff (reset)
      line_cnt_ff <= 3'(MAX_LINES))
      else $error("line count beyond limit");
endmodule

### hw/rtl/lcc_ctrl.sv
module lcc_ctrl (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [1:0] req_type,
   output logic rsp_tvalid,
   input logic rsp_tready,
   input lcc_pkg::status_type status,
   output lcc_pkg::cmd_type cmd
);
   import lcc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_PA, ST_PB, ST_JUDGE, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [LINE_IDX_W:0] k_ff, k_in;
   logic rv_ff, rv_in;
   logic take;

   assign req_tready = (state_ff == ST_IDLE) && !rv_ff;
   assign take = req_tvalid && req_tready;
   assign rsp_tvalid = rv_ff;

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      rv_in = rv_ff && !rsp_tready;
      cmd = '0;
      cmd.line_idx = k_ff[LINE_IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.load = 1'b1;
               k_in = '0;
               if (req_type == REQ_OBJECT) state_in = ST_READ;
               else begin
                  if (req_type == REQ_CLEAR) cmd.clear_live = 1'b1;
                  else cmd.sweep = 1'b1;
                  rv_in = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.read_slot = 1'b1;
            if (status.is_object && status.is_live && status.line_cnt != '0)
               state_in = ST_PA;
            else state_in = ST_DONE;
         end
         ST_PA: begin
            cmd.prod_a = 1'b1;
            state_in = ST_PB;
         end
         ST_PB: begin
            cmd.prod_b = 1'b1;
            state_in = ST_JUDGE;
         end
         ST_JUDGE: begin
            cmd.judge = 1'b1;
            k_in = k_ff + 1'b1;
            if (3'(k_in) >= status.line_cnt) state_in = ST_DONE;
            else state_in = ST_PA;
         end
         ST_DONE: begin
            cmd.commit = 1'b1;
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         rv_ff <= rv_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_tready |=> rv_ff)
      else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_tready)
      else $error("accept while busy");
endmodule

### bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lcc_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [79:0] rsp_tdata;
   logic csr_wr_en = 0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [LINE_W-1:0] csr_wdata = '0;

   line_crossing_counter_core dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   typedef struct {
      logic [1:0] kind;
      logic [8:0] tid;
      logic [11:0] bx, by, bw, bh;
   } det_type;

   typedef struct {
      det_type d;
      bit typed;
      rsp_item_type exp;
   } row_type;

   // predictor state
   logic [2:0] m_count;
   logic [LINE_W-1:0] m_line [MAX_LINES];
   bit m_live [TRACK_SLOTS];
   bit m_seen [TRACK_SLOTS];
   logic [13:0] m_px [TRACK_SLOTS];
   logic [13:0] m_py [TRACK_SLOTS];
   logic [3:0] m_mask [TRACK_SLOTS];
   logic [31:0] m_in, m_out;

   rsp_item_type pending_q [$];
   int errors = 0;
   bit calm = 0;
   bit long_hold = 0;

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
   endtask

   function automatic longint cross3(longint ax, ay, bx, by, cx, cy);
      return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
   endfunction

   function automatic bit opposite(longint a, longint b);
      return (a > 0 && b < 0) || (a < 0 && b > 0);
   endfunction

   function automatic rsp_item_type predict_crossing(det_type d);
      rsp_item_type r;
      int slot, n;
      longint fx, fy, px, py, x0, y0, x1, y1;
      logic [1:0] code;
      bit is_in;
      r = '0;
      if (d.kind == REQ_OBJECT) begin
         if (!d.tid[8]) begin
            slot = d.tid[7:0];
            fx = 2 * longint'(d.bx) + d.bw;
            fy = 2 * (longint'(d.by) + d.bh);
            m_seen[slot] = 1;
            if (m_live[slot]) begin
               px = m_px[slot];
               py = m_py[slot];
               n = (m_count > MAX_LINES) ? MAX_LINES : m_count;
               for (int k = 0; k < n; k++) begin
                  x0 = m_line[k][13:0];
                  y0 = m_line[k][27:14];
                  x1 = m_line[k][41:28];
                  y1 = m_line[k][55:42];
                  code = m_line[k][57:56];
                  if (m_mask[slot][k]) continue;
                  if (!(opposite(cross3(px, py, fx, fy, x0, y0), cross3(px, py, fx, fy, x1, y1))
                        && opposite(cross3(x0, y0, x1, y1, px, py),
                                    cross3(x0, y0, x1, y1, fx, fy))))
                     continue;
                  case (code)
                     DIR_UP: is_in = fy < py;
                     DIR_RIGHT: is_in = fx > px;
                     DIR_LEFT: is_in = fx < px;
                     default: is_in = fy > py;
                  endcase
                  if (is_in) begin
                     if (m_in != '1) m_in++;
                     r.in_lines[k] = 1;
                     r.direction = OUT_IN;
                  end else begin
                     if (m_out != '1) m_out++;
                     r.out_lines[k] = 1;
                     r.direction = OUT_OUT;
                  end
                  r.crossed = 1;
                  m_mask[slot][k] = 1;
               end
            end else begin
               m_live[slot] = 1;
               m_mask[slot] = 0;
            end
            m_px[slot] = fx[13:0];
            m_py[slot] = fy[13:0];
         end
      end else if (d.kind == REQ_CLEAR) begin
         foreach (m_live[s]) begin
            m_live[s] = 0;
            m_seen[s] = 0;
         end
      end else begin
         foreach (m_live[s]) begin
            if (!m_seen[s]) m_live[s] = 0;
            m_seen[s] = 0;
         end
      end
      r.total_in = m_in;
      r.total_out = m_out;
      return r;
   endfunction

   task automatic send(det_type d, bit typed = 0, rsp_item_type fixed = '0);
      rsp_item_type p;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= d.kind;
      req_tdata <= {7'b0, d.bh, d.bw, d.by, d.bx, d.tid};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      p = predict_crossing(d);
      pending_q.push_back(typed ? fixed : p);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] a, logic [LINE_W-1:0] v);
      req_tvalid <= 0;
      wait (pending_q.size() == 0);
      repeat (20) @(posedge clock);
      csr_wr_en <= 1;
      csr_addr <= a;
      csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      if (a == CSR_LINE_COUNT) m_count = v[2:0];
      else m_line[a - 1] = v;
   endtask

   function automatic logic [LINE_W-1:0] mk_line(int x0, y0, x1, y1, logic [1:0] c);
      return {c, 14'(y1), 14'(x1), 14'(y0), 14'(x0)};
   endfunction

   function automatic rsp_item_type mk_rsp(bit c, logic [1:0] dr, logic [3:0] il, ol,
                                           logic [31:0] ti, to);
      rsp_item_type r;
      r = '0;
      r.crossed = c;
      r.direction = dr;
      r.in_lines = il;
      r.out_lines = ol;
      r.total_in = ti;
      r.total_out = to;
      return r;
   endfunction

   function automatic row_type mk_row(logic [1:0] k, logic [8:0] id, logic [11:0] x, y, w, h,
                                      bit typed = 0, rsp_item_type e = '0);
      row_type r;
      r.d = '{k, id, x, y, w, h};
      r.typed = typed;
      r.exp = e;
      return r;
   endfunction

   // receiver
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end
         if (calm) rsp_tready <= 1;
         else if (idle > 0) begin
            idle--;
            rsp_tready <= 0;
         end else if ($urandom_range(0, 5) == 0) begin
            idle = $urandom_range(1, 9) - 1;
            rsp_tready <= 0;
         end else rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      rsp_item_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_item_type'(rsp_tdata[$bits(rsp_item_type)-1:0]);
         if (pending_q.size() == 0) report("unexpected item", 0, 0);
         else begin
            want = pending_q.pop_front();
            if (got.crossed !== want.crossed) report("crossed", got.crossed, want.crossed);
            if (got.direction !== want.direction)
               report("direction", got.direction, want.direction);
            if (got.in_lines !== want.in_lines) report("in_lines", got.in_lines, want.in_lines);
            if (got.out_lines !== want.out_lines)
               report("out_lines", got.out_lines, want.out_lines);
            if (got.total_in !== want.total_in) report("total_in", got.total_in, want.total_in);
            if (got.total_out !== want.total_out)
               report("total_out", got.total_out, want.total_out);
         end
      end
   end

   initial begin
      #2ms;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      row_type rows [$];
      int cnts [7] = '{4, 7, 0, 1, 3, 4, 2};
      int px [12], py [12];
      logic [8:0] pool [12];
      det_type d;
      int r, j;

      m_count = 0;
      m_in = 0;
      m_out = 0;
      foreach (m_line[i]) m_line[i] = '0;
      foreach (m_live[i]) begin
         m_live[i] = 0;
         m_seen[i] = 0;
         m_px[i] = 0;
         m_py[i] = 0;
         m_mask[i] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 0;

      write_reg(CSR_LINE_COUNT, 2);
      write_reg(1, mk_line(0, 1000, 8000, 1000, DIR_DOWN));
      write_reg(2, mk_line(1000, 0, 1000, 16000, DIR_RIGHT));

      rows.push_back(mk_row(REQ_OBJECT, 9'h1FF, '1, '1, '1, '1, 1, mk_rsp(0, 0, 0, 0, 0, 0)));
      rows.push_back(mk_row(REQ_SWEEP, 0, 0, 0, 0, 0, 1, mk_rsp(0, 0, 0, 0, 0, 0)));
      rows.push_back(mk_row(2'd3, 9'h0AA, 1, 2, 3, 4, 1, mk_rsp(0, 0, 0, 0, 0, 0)));
      rows.push_back(mk_row(REQ_CLEAR, 0, 0, 0, 0, 0, 1, mk_rsp(0, 0, 0, 0, 0, 0)));
      rows.push_back(mk_row(REQ_OBJECT, 5, 400, 100, 0, 100, 1, mk_rsp(0, 0, 0, 0, 0, 0)));
      rows.push_back(mk_row(REQ_OBJECT, 5, 400, 600, 0, 0, 1, mk_rsp(1, OUT_IN, 1, 0, 1, 0)));
      rows.push_back(mk_row(REQ_OBJECT, 5, 600, 600, 0, 0, 1, mk_rsp(1, OUT_IN, 2, 0, 2, 0)));
      rows.push_back(mk_row(REQ_OBJECT, 5, 400, 600, 0, 0));
      rows.push_back(mk_row(REQ_OBJECT, 9'h100, 10, 10, 10, 10));
      rows.push_back(mk_row(REQ_OBJECT, 255, '1, '1, '1, '1));
      rows.push_back(mk_row(REQ_OBJECT, 255, 0, 0, 0, 0));
      rows.push_back(mk_row(REQ_OBJECT, 7, 400, 500, 0, 0));
      rows.push_back(mk_row(REQ_OBJECT, 7, 400, 700, 0, 0));
      rows.push_back(mk_row(REQ_OBJECT, 0, 2000, 2000, 8, 8));
      rows.push_back(mk_row(REQ_SWEEP, 0, 0, 0, 0, 0));
      rows.push_back(mk_row(REQ_SWEEP, 0, 0, 0, 0, 0));
      rows.push_back(mk_row(REQ_OBJECT, 5, 400, 100, 0, 100));
      rows.push_back(mk_row(REQ_OBJECT, 5, 400, 600, 0, 0));
      foreach (rows[i]) send(rows[i].d, rows[i].typed, rows[i].exp);

      for (int ph = 0; ph < 7; ph++) begin
         write_reg(CSR_LINE_COUNT, LINE_W'(cnts[ph]));
         for (int k = 1; k <= MAX_LINES; k++) begin
            if (ph == 0 && k == 1) write_reg(CSR_ADDR_W'(k), '1);
            else if (ph == 1 && k == 2) write_reg(CSR_ADDR_W'(k), '0);
            else if (ph == 2) write_reg(CSR_ADDR_W'(k), LINE_W'({$urandom, $urandom}));
            else write_reg(CSR_ADDR_W'(k),
                           mk_line($urandom_range(0, 9000), $urandom_range(0, 9000),
                                   $urandom_range(0, 9000), $urandom_range(0, 9000),
                                   2'($urandom)));
         end
         foreach (pool[i]) begin
            pool[i] = $urandom_range(0, 255);
            px[i] = $urandom_range(0, 4095);
            py[i] = $urandom_range(0, 4095);
         end
         if (ph == 1) long_hold = 1;
         if (ph == 6) calm = 1;
         for (int n = 0; n < 240; n++) begin
            r = $urandom_range(0, 99);
            d = '{REQ_OBJECT, 0, 0, 0, 0, 0};
            if (r < 78) begin
               j = $urandom_range(0, 11);
               px[j] += int'($urandom_range(0, 600)) - 300;
               py[j] += int'($urandom_range(0, 600)) - 300;
               if (px[j] < 0) px[j] = 0;
               if (px[j] > 4095) px[j] = 4095;
               if (py[j] < 0) py[j] = 0;
               if (py[j] > 4095) py[j] = 4095;
               d.tid = pool[j];
               d.bx = 12'(px[j]);
               d.by = 12'(py[j]);
               d.bw = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 63));
               d.bh = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 63));
            end else if (r < 86) d = '{REQ_OBJECT, 9'($urandom), 12'($urandom), 12'($urandom),
                                       12'($urandom), 12'($urandom)};
            else if (r < 94) d.kind = REQ_SWEEP;
            else if (r < 96) d.kind = REQ_CLEAR;
            else if (r < 98) d = '{2'd3, 9'($urandom), 12'($urandom), 12'($urandom),
                                   12'($urandom), 12'($urandom)};
            else d = '{REQ_OBJECT, 9'h100 | 9'($urandom), 12'($urandom), 12'($urandom),
                       12'($urandom), 12'($urandom)};
            send(d);
         end
      end
      req_tvalid <= 0;
      wait (pending_q.size() == 0);
      repeat (40) @(posedge clock);
      if (errors == 0 && pending_q.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
